[rtl/rlbc_pkg.sv]
// ----------------------------------------------------------------------------
// rlbc_pkg
// Shared constants and types of the run-length byte codec: size limits,
// header codes, and the command and status bundles of controller and datapath.
// ----------------------------------------------------------------------------
package rlbc_pkg;

    localparam int MAX_LITERAL = 32;
    localparam int MAX_RUN     = 127;

    localparam int LIT_AW = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
    localparam int LIT_CW = $clog2(MAX_LITERAL + 1);
    localparam int RUN_W  = 7;

    localparam logic [7:0]       RUN_FLAG      = 8'h80;
    localparam logic [RUN_W-1:0] RUN_START_LEN = RUN_W'(2);
    localparam logic [RUN_W-1:0] REP_ONE       = RUN_W'(1);
    localparam logic [RUN_W-1:0] RUN_LIMIT     = RUN_W'(MAX_RUN);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_RUN    = 2'd1,
        PH_LIT    = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        EC_FIRST,
        EC_RUN_GROW,
        EC_RUN_END,
        EC_RUN_START,
        EC_LITERAL
    } t_enc_case;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_TAKE_FIRST,
        OP_RUN_INC,
        OP_RUN_START,
        OP_APPEND,
        OP_DEC
    } t_op;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_RUN_HDR,
        EM_RUN_DAT,
        EM_FL_HDR,
        EM_FL_DAT,
        EM_DEC
    } t_emit;

    typedef struct packed {
        t_op   op;
        t_emit emit;
        logic  emit_last;
        logic  end_stream;
    } t_cmd;

    typedef struct packed {
        logic      mode;
        t_enc_case enc_case;
        logic      in_run;
        logic      last;
        logic      lit_nonzero;
        logic      lit_full_next;
        logic      fl_last;
        logic      out_space;
        logic      dec_emit;
    } t_stat;

endpackage

[rtl/rlbc_if.sv]
// ----------------------------------------------------------------------------
// rlbc_if
// Valid/ready channels of the codec: input byte request and result request.
// ----------------------------------------------------------------------------
interface rlbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface rlbc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [6:0] repeat_res;
    logic       out_last;

    modport source (output valid, output out_byte, output repeat_res, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input repeat_res, input out_last,
                    output ready);
endinterface

[rtl/rlbc_dpath.sv]
// ----------------------------------------------------------------------------
// rlbc_dpath
// Datapath: stream state, literal buffer memory, decode phase and the
// result output register. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module rlbc_dpath
    import rlbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [6:0]  o_repeat_res,
    output logic        o_out_last
);

    logic              r_mode, n_mode;
    logic [7:0]        r_byte, n_byte;
    logic              r_last, n_last;
    logic [7:0]        r_prev, n_prev;
    logic              r_have, n_have;
    logic              r_in_run, n_in_run;
    logic [RUN_W-1:0]  r_run_cnt, n_run_cnt;
    logic [LIT_CW-1:0] r_lit_cnt, n_lit_cnt;
    logic [LIT_CW-1:0] r_idx, n_idx;
    t_phase            r_phase, n_phase;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_byte, n_out_byte;
    logic [RUN_W-1:0]  r_out_rep, n_out_rep;
    logic              r_out_last, n_out_last;

    logic [7:0]        r_mem [MAX_LITERAL];
    logic [7:0]        r_rd_data;
    logic              rd_en;
    logic [LIT_AW-1:0] rd_addr;
    logic              wr_en;

    logic [LIT_CW-1:0] idx_inc;
    logic              fl_last;
    logic              out_space;
    t_enc_case         enc_case;

    assign idx_inc   = LIT_CW'(r_idx + LIT_CW'(1));
    assign fl_last   = (idx_inc == r_lit_cnt);
    assign out_space = !r_out_valid || i_out_ready;
    assign wr_en     = (i_cmd.op == OP_APPEND);

    always_comb begin
        if (!r_have) begin
            enc_case = EC_FIRST;
        end else if (r_in_run) begin
            enc_case = (r_byte == r_prev && r_run_cnt < RUN_LIMIT) ? EC_RUN_GROW
                                                                   : EC_RUN_END;
        end else if (r_byte == r_prev) begin
            enc_case = EC_RUN_START;
        end else begin
            enc_case = EC_LITERAL;
        end
    end

    always_comb begin
        o_stat.mode          = r_mode;
        o_stat.enc_case      = enc_case;
        o_stat.in_run        = r_in_run;
        o_stat.last          = r_last;
        o_stat.lit_nonzero   = (r_lit_cnt != '0);
        o_stat.lit_full_next = (r_lit_cnt == LIT_CW'(MAX_LITERAL - 1));
        o_stat.fl_last       = fl_last;
        o_stat.out_space     = out_space;
        o_stat.dec_emit      = (r_phase == PH_RUN && r_run_cnt != '0) || (r_phase == PH_LIT);
    end

    always_comb begin
        n_mode      = r_mode;
        n_byte      = r_byte;
        n_last      = r_last;
        n_prev      = r_prev;
        n_have      = r_have;
        n_in_run    = r_in_run;
        n_run_cnt   = r_run_cnt;
        n_lit_cnt   = r_lit_cnt;
        n_idx       = r_idx;
        n_phase     = r_phase;
        n_out_byte  = r_out_byte;
        n_out_rep   = r_out_rep;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !i_out_ready;
        rd_en       = 1'b0;
        rd_addr     = '0;

        case (i_cmd.op)
            OP_LOAD: begin
                n_byte = i_in_byte;
                n_last = i_in_last;
            end
            OP_TAKE_FIRST: begin
                n_prev   = r_byte;
                n_have   = 1'b1;
                n_in_run = 1'b0;
            end
            OP_RUN_INC: begin
                n_run_cnt = RUN_W'(r_run_cnt + REP_ONE);
            end
            OP_RUN_START: begin
                n_in_run  = 1'b1;
                n_run_cnt = RUN_START_LEN;
            end
            OP_APPEND: begin
                n_lit_cnt = LIT_CW'(r_lit_cnt + LIT_CW'(1));
                n_prev    = r_byte;
            end
            OP_DEC: begin
                case (r_phase)
                    PH_RUN: begin
                        n_run_cnt = '0;
                        n_phase   = PH_HEADER;
                    end
                    PH_LIT: begin
                        n_run_cnt = RUN_W'(r_run_cnt - REP_ONE);
                        n_phase   = (r_run_cnt == REP_ONE) ? PH_HEADER : PH_LIT;
                    end
                    default: begin
                        n_run_cnt = r_byte[6:0];
                        if (r_byte[7]) begin
                            n_phase = PH_RUN;
                        end else begin
                            n_phase = (r_byte[6:0] != '0) ? PH_LIT : PH_HEADER;
                        end
                    end
                endcase
                // stream end drops an unfinished block
                if (r_last) begin
                    n_phase   = PH_HEADER;
                    n_run_cnt = '0;
                end
            end
            default: begin
            end
        endcase

        case (i_cmd.emit)
            EM_RUN_HDR: begin
                n_out_byte = RUN_FLAG | {1'b0, r_run_cnt};
                n_out_rep  = REP_ONE;
            end
            EM_RUN_DAT: begin
                n_out_byte = r_prev;
                n_out_rep  = REP_ONE;
                n_prev     = r_byte;
                n_in_run   = 1'b0;
                n_run_cnt  = '0;
            end
            EM_FL_HDR: begin
                n_out_byte = 8'(r_lit_cnt);
                n_out_rep  = REP_ONE;
                n_idx      = '0;
                rd_en      = 1'b1;
                rd_addr    = '0;
            end
            EM_FL_DAT: begin
                n_out_byte = r_rd_data;
                n_out_rep  = REP_ONE;
                n_idx      = idx_inc;
                rd_en      = 1'b1;
                rd_addr    = idx_inc[LIT_AW-1:0];
                if (fl_last) begin
                    n_lit_cnt = '0;
                end
            end
            EM_DEC: begin
                n_out_byte = r_byte;
                n_out_rep  = (r_phase == PH_RUN) ? r_run_cnt : REP_ONE;
            end
            default: begin
            end
        endcase

        if (i_cmd.emit != EM_NONE) begin
            n_out_valid = 1'b1;
            n_out_last  = i_cmd.emit_last;
        end

        if (i_cmd.end_stream) begin
            n_prev    = '0;
            n_have    = 1'b0;
            n_in_run  = 1'b0;
            n_run_cnt = '0;
            n_lit_cnt = '0;
        end

        // a mode write starts a fresh stream
        if (i_cfg_we) begin
            n_mode    = i_cfg_data;
            n_prev    = '0;
            n_have    = 1'b0;
            n_in_run  = 1'b0;
            n_run_cnt = '0;
            n_lit_cnt = '0;
            n_phase   = PH_HEADER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_prev      <= '0;
            r_have      <= 1'b0;
            r_in_run    <= 1'b0;
            r_run_cnt   <= '0;
            r_lit_cnt   <= '0;
            r_phase     <= PH_HEADER;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_prev      <= n_prev;
            r_have      <= n_have;
            r_in_run    <= n_in_run;
            r_run_cnt   <= n_run_cnt;
            r_lit_cnt   <= n_lit_cnt;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_last     <= n_last;
        r_idx      <= n_idx;
        r_out_byte <= n_out_byte;
        r_out_rep  <= n_out_rep;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_lit_cnt[LIT_AW-1:0]] <= r_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_repeat_res = r_out_rep;
    assign o_out_last   = r_out_last;

`ifndef ASSERT_OFF
    a_lit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lit_cnt <= LIT_CW'(MAX_LITERAL))
        else $error("literal count beyond buffer size");

    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_run |-> (r_run_cnt >= RUN_START_LEN))
        else $error("open run shorter than two bytes");

    a_flush_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit == EM_FL_DAT) |-> (r_idx < r_lit_cnt))
        else $error("literal read past buffered bytes");
`endif

endmodule

[rtl/rlbc_ctrl.sv]
// ----------------------------------------------------------------------------
// rlbc_ctrl
// Controller: sequences one input byte through encode or decode and steps
// the run and literal-flush emissions into the output register.
// ----------------------------------------------------------------------------
module rlbc_ctrl
    import rlbc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_RUN_HDR,
        S_RUN_DAT,
        S_FL_HDR,
        S_FL_DAT,
        S_LAST,
        S_DEC
    } t_state;

    t_state r_state, n_state;
    logic   r_tail, n_tail;
    logic   more;

    // stream end still owes a run or flush after the current sequence
    assign more       = i_stat.last && !r_tail;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state          = r_state;
        n_tail           = r_tail;
        o_cmd.op         = OP_NONE;
        o_cmd.emit       = EM_NONE;
        o_cmd.emit_last  = 1'b0;
        o_cmd.end_stream = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_tail   = 1'b0;
                    n_state  = i_stat.mode ? S_DEC : S_EVAL;
                end
            end
            S_EVAL: begin
                case (i_stat.enc_case)
                    EC_FIRST: begin
                        o_cmd.op = OP_TAKE_FIRST;
                        n_state  = S_LAST;
                    end
                    EC_RUN_GROW: begin
                        o_cmd.op = OP_RUN_INC;
                        n_state  = S_LAST;
                    end
                    EC_RUN_END: begin
                        n_state = S_RUN_HDR;
                    end
                    EC_RUN_START: begin
                        o_cmd.op = OP_RUN_START;
                        n_state  = i_stat.lit_nonzero ? S_FL_HDR : S_LAST;
                    end
                    EC_LITERAL: begin
                        o_cmd.op = OP_APPEND;
                        n_state  = i_stat.lit_full_next ? S_FL_HDR : S_LAST;
                    end
                    default: begin
                        n_state = S_LAST;
                    end
                endcase
            end
            S_RUN_HDR: begin
                if (i_stat.out_space) begin
                    o_cmd.emit = EM_RUN_HDR;
                    n_state    = S_RUN_DAT;
                end
            end
            S_RUN_DAT: begin
                if (i_stat.out_space) begin
                    o_cmd.emit      = EM_RUN_DAT;
                    o_cmd.emit_last = !more;
                    if (r_tail) begin
                        o_cmd.end_stream = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_state = S_LAST;
                    end
                end
            end
            S_FL_HDR: begin
                if (i_stat.out_space) begin
                    o_cmd.emit = EM_FL_HDR;
                    n_state    = S_FL_DAT;
                end
            end
            S_FL_DAT: begin
                if (i_stat.out_space) begin
                    o_cmd.emit      = EM_FL_DAT;
                    o_cmd.emit_last = i_stat.fl_last && !more;
                    if (i_stat.fl_last) begin
                        if (r_tail) begin
                            o_cmd.end_stream = 1'b1;
                            n_state          = S_IDLE;
                        end else begin
                            n_state = S_LAST;
                        end
                    end
                end
            end
            S_LAST: begin
                if (!i_stat.last) begin
                    n_state = S_IDLE;
                end else begin
                    n_tail = 1'b1;
                    if (i_stat.in_run) begin
                        n_state = S_RUN_HDR;
                    end else begin
                        // pending byte joins the buffer, then everything flushes
                        o_cmd.op = OP_APPEND;
                        n_state  = S_FL_HDR;
                    end
                end
            end
            S_DEC: begin
                if (!i_stat.dec_emit || i_stat.out_space) begin
                    o_cmd.op = OP_DEC;
                    if (i_stat.dec_emit) begin
                        o_cmd.emit      = EM_DEC;
                        o_cmd.emit_last = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tail  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tail  <= n_tail;
        end
    end

`ifndef ASSERT_OFF
    a_tail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail && (r_state != S_IDLE) |-> i_stat.last)
        else $error("stream-end sequence without final byte");

    a_emit_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit != EM_NONE) |-> i_stat.out_space)
        else $error("result issued into an occupied output register");

    a_dec_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC) |-> i_stat.mode)
        else $error("decode step while in encode mode");
`endif

endmodule

[rtl/run_length_byte_codec.sv]
// ----------------------------------------------------------------------------
// run_length_byte_codec
// Byte-stream run-length codec with packed header bytes (bit 7 = run).
// Usage: write the mode register (0 encode, 1 decode) while idle; each write
// starts a new stream. Bytes enter on i_in with valid/ready, in_last closing
// the stream. Results leave on o_out, one request per packed or decoded byte;
// out_last marks the final result caused by an input byte.
// Steps: an encode byte passes through the evaluate and end-check states
// before the next byte can be taken; a run adds a header and a byte step, a
// literal flush adds a header step and one step per buffered byte, read one
// per cycle from the literal buffer while the output register has space.
// A decode byte takes a single decode step. The first result of a byte is
// registered from the decode state, or in encode from a header state.
// The output register lets the next byte be accepted while the last result
// still waits; when the receiver stalls, the sequence holds until the
// register drains. Synchronous reset clears mode to encode and all stream
// state; the literal buffer itself is not cleared.
// ----------------------------------------------------------------------------
module run_length_byte_codec
    import rlbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    rlbc_in_if.sink   i_in,
    rlbc_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    rlbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rlbc_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_byte    (i_in.in_byte),
        .i_in_last    (i_in.in_last),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_byte   (o_out.out_byte),
        .o_repeat_res (o_out.repeat_res),
        .o_out_last   (o_out.out_last)
    );

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for run_length_byte_codec. A scoreboard class predicts
// the packed or decoded result requests of every accepted input byte and
// checks each result in order. Directed streams are followed by random encode
// and decode streams, with random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import rlbc_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_LIMIT    = 4000;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int IDLE_PCT       = 29;

    typedef struct packed {
        logic [7:0]       data;
        logic [RUN_W-1:0] rep;
        logic             last;
    } t_result;

    typedef enum logic [1:0] {
        SEG_RUN,
        SEG_LIT,
        SEG_NOISE
    } t_seg;

    class codec_scoreboard;
        logic             mode;
        logic [7:0]       prev_byte;
        logic             have_prev;
        logic             in_run;
        logic [RUN_W-1:0] run_len;
        logic [7:0]       lit_buf[MAX_LITERAL];
        logic [LIT_CW-1:0] lit_cnt;
        t_phase           phase;
        t_result          pending[$];
        int               errors;

        function new();
            errors = 0;
            set_mode(1'b0);
        endfunction

        function void set_mode(logic m);
            mode      = m;
            prev_byte = '0;
            have_prev = 1'b0;
            in_run    = 1'b0;
            run_len   = '0;
            lit_cnt   = '0;
            phase     = PH_HEADER;
        endfunction

        function void push(logic [7:0] d, logic [RUN_W-1:0] r);
            pending.push_back('{data: d, rep: r, last: 1'b0});
        endfunction

        function void flush_lits();
            if (lit_cnt == 0)
                return;
            push(8'(lit_cnt), REP_ONE);
            for (int k = 0; k < lit_cnt; k++)
                push(lit_buf[k], REP_ONE);
            lit_cnt = '0;
        endfunction

        function void add_lit(logic [7:0] d);
            if (lit_cnt >= MAX_LITERAL)
                flush_lits();
            lit_buf[lit_cnt] = d;
            lit_cnt++;
            if (lit_cnt >= MAX_LITERAL)
                flush_lits();
        endfunction

        function void emit_run();
            push(RUN_FLAG | {1'b0, run_len}, REP_ONE);
            push(prev_byte, REP_ONE);
            in_run  = 1'b0;
            run_len = '0;
        endfunction

        function void encode_byte(logic [7:0] d, logic lst);
            if (!have_prev) begin
                prev_byte = d;
                have_prev = 1'b1;
                in_run    = 1'b0;
            end else if (in_run) begin
                if (d == prev_byte && run_len < RUN_LIMIT) begin
                    run_len++;
                end else begin
                    emit_run();
                    prev_byte = d;
                end
            end else if (d == prev_byte) begin
                flush_lits();
                in_run  = 1'b1;
                run_len = RUN_START_LEN;
            end else begin
                add_lit(prev_byte);
                prev_byte = d;
            end
            if (lst) begin
                // stream end: close an open run, else flush the pending byte
                if (in_run) begin
                    emit_run();
                end else if (have_prev) begin
                    add_lit(prev_byte);
                    flush_lits();
                end
                have_prev = 1'b0;
                in_run    = 1'b0;
                run_len   = '0;
                lit_cnt   = '0;
                prev_byte = '0;
            end
        endfunction

        function void decode_byte(logic [7:0] d, logic lst);
            case (phase)
                PH_RUN: begin
                    if (run_len != 0)
                        push(d, run_len);
                    run_len = '0;
                    phase   = PH_HEADER;
                end
                PH_LIT: begin
                    push(d, REP_ONE);
                    run_len--;
                    if (run_len == 0)
                        phase = PH_HEADER;
                end
                default: begin
                    run_len = d[RUN_W-1:0];
                    if (d[7])
                        phase = PH_RUN;
                    else if (run_len != 0)
                        phase = PH_LIT;
                    else
                        phase = PH_HEADER;
                end
            endcase
            // an unfinished block is dropped at stream end
            if (lst) begin
                phase   = PH_HEADER;
                run_len = '0;
            end
        endfunction

        function void note_input(logic [7:0] d, logic lst);
            int base;
            base = pending.size();
            if (mode)
                decode_byte(d, lst);
            else
                encode_byte(d, lst);
            if (pending.size() > base)
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [7:0] d, logic [RUN_W-1:0] r, logic lst);
            t_result exp_res;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result byte=%h rep=%0d last=%b",
                                          d, r, lst));
                return;
            end
            exp_res = pending.pop_front();
            if (d !== exp_res.data || r !== exp_res.rep || lst !== exp_res.last)
                report_mismatch($sformatf("got byte=%h rep=%0d last=%b, want %h %0d %b",
                                          d, r, lst, exp_res.data, exp_res.rep,
                                          exp_res.last));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;
    bit   no_idle;
    int   bytes_sent;

    codec_scoreboard sb;

    rlbc_in_if  in_ch();
    rlbc_out_if out_ch();

    run_length_byte_codec u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // result side: check accepted requests, stall at random
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.out_byte, out_ch.repeat_res, out_ch.out_last);
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic send_byte(input logic [7:0] d, input logic lst);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= d;
        in_ch.in_last <= lst;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_input(d, lst);
        bytes_sent++;
    endtask

    task automatic wait_codec_idle();
        int n;
        in_ch.valid <= 1'b0;
        n = 0;
        while (sb.pending.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge clk);
            n++;
        end
        if (sb.pending.size() != 0) begin
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
            sb.pending.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        sb.set_mode(m);
    endtask

    task automatic encode_stream_burst(input int budget, input bit with_extremes);
        int         start;
        int         seg;
        int         len;
        t_seg       kind;
        logic [7:0] val;
        logic [7:0] base;
        logic [7:0] prev_val;
        logic       lst;
        start    = bytes_sent;
        seg      = 0;
        prev_val = '0;
        while (bytes_sent - start < budget) begin
            if (with_extremes && seg == 0) begin
                // run past the length limit, so it gets split
                kind = SEG_RUN;
                len  = $urandom_range(MAX_RUN + 1, MAX_RUN + 4);
            end else if (with_extremes && seg == 1) begin
                kind = SEG_LIT;
                len  = $urandom_range(MAX_LITERAL + 1, MAX_LITERAL + 4);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        kind = SEG_RUN;
                        len  = $urandom_range(2, 8);
                    end
                    4, 5, 6, 7: begin
                        kind = SEG_LIT;
                        len  = $urandom_range(1, 12);
                    end
                    default: begin
                        kind = SEG_NOISE;
                        len  = $urandom_range(1, 10);
                    end
                endcase
            end
            base = 8'($urandom_range(0, 255));
            for (int i = 0; i < len; i++) begin
                case (kind)
                    SEG_RUN: val = base;
                    SEG_LIT: do val = 8'($urandom_range(0, 255)); while (val == prev_val);
                    default: val = base ^ 8'($urandom_range(0, 1));
                endcase
                lst = (seg >= 2 || !with_extremes) && ($urandom_range(0, 39) == 0);
                send_byte(val, lst);
                prev_val = val;
            end
            seg++;
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic decode_stream_burst(input int budget);
        int start;
        int cnt;
        int cut;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    cnt = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, MAX_RUN);
                    send_byte(RUN_FLAG | 8'(cnt), 1'b0);
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
                end
                4, 5, 6, 7: begin
                    if ($urandom_range(0, 9) == 0)
                        cnt = 0;
                    else if ($urandom_range(0, 5) == 0)
                        cnt = $urandom_range(7, 40);
                    else
                        cnt = $urandom_range(1, 6);
                    // sometimes the stream ends part way through the block
                    if (cnt > 1 && $urandom_range(0, 7) == 0)
                        cut = $urandom_range(1, cnt - 1);
                    else
                        cut = cnt;
                    send_byte(8'(cnt), 1'b0);
                    for (int k = 1; k <= cut; k++)
                        send_byte(8'($urandom_range(0, 255)),
                                  k == cut && (cut < cnt || $urandom_range(0, 9) == 0));
                end
                8: repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                default: send_byte(8'($urandom_range(0, 255)), 1'b1);
            endcase
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        sb            = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        in_ch.in_last = 1'b0;
        out_ch.ready  = 1'b0;
        no_idle       = 1'b0;
        bytes_sent    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // encode after reset: lone byte, short run, mixed, extremes
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b1);
        wait_codec_idle();

        write_mode(1'b1);
        // zero-count run and literal headers emit nothing
        send_byte(8'h80, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'hFF, 1'b1);
        // literal block cut short by stream end, then a header with end
        send_byte(8'h05, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b1);
        send_byte(8'h83, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'hC3, 1'b0);
        wait_codec_idle();

        write_mode(1'b0);
        encode_stream_burst(150, 1'b1);
        wait_codec_idle();

        write_mode(1'b1);
        decode_stream_burst(70);
        wait_codec_idle();

        // back-to-back stretch: no gaps and no stalls
        no_idle = 1'b1;
        write_mode(1'b0);
        encode_stream_burst(70, 1'b0);
        wait_codec_idle();
        no_idle = 1'b0;

        write_mode(1'b1);
        write_mode(1'b1);
        decode_stream_burst(70);
        wait_codec_idle();

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 20);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
rtl/rlbc_pkg.sv
rtl/rlbc_if.sv
rtl/rlbc_dpath.sv
rtl/rlbc_ctrl.sv
rtl/run_length_byte_codec.sv
bench/tb.sv
